[sv/mqttd_pkg.sv]
// Shared types, codes and constants of the MQTT receive deframer.
// No dependencies; used by the result channel interface and all modules.
package mqttd_pkg;

   // Remaining-length field may span at most this many bytes (1 to 4)
   localparam int unsigned MAX_LENGTH_BYTES = 4;

   localparam int unsigned LEN_W = 28;
   localparam int unsigned CNT_W = 3;

   // Parser phase codes
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;
   localparam logic [1:0] PH_HALT   = 2'd3;

   // Control packet types (upper nibble of the fixed header)
   localparam logic [3:0] TYPE_CONNACK  = 4'h2;
   localparam logic [3:0] TYPE_PUBLISH  = 4'h3;
   localparam logic [3:0] TYPE_PUBACK   = 4'h4;
   localparam logic [3:0] TYPE_SUBACK   = 4'h9;
   localparam logic [3:0] TYPE_UNSUBACK = 4'hB;
   localparam logic [3:0] TYPE_PINGRESP = 4'hD;

   // Byte classes
   localparam logic [3:0] KIND_HEADER    = 4'd0;
   localparam logic [3:0] KIND_LENGTH    = 4'd1;
   localparam logic [3:0] KIND_TOPIC_LEN = 4'd2;
   localparam logic [3:0] KIND_TOPIC     = 4'd3;
   localparam logic [3:0] KIND_PKT_ID    = 4'd4;
   localparam logic [3:0] KIND_PAYLOAD   = 4'd5;
   localparam logic [3:0] KIND_OTHER     = 4'd6;
   localparam logic [3:0] KIND_CONNACK   = 4'd7;
   localparam logic [3:0] KIND_DISCARD   = 4'd8;

   // Packet events
   localparam logic [3:0] EV_NONE        = 4'd0;
   localparam logic [3:0] EV_CONNACK_OK  = 4'd1;
   localparam logic [3:0] EV_CONNACK_REJ = 4'd2;
   localparam logic [3:0] EV_PUBLISH     = 4'd3;
   localparam logic [3:0] EV_SUBACK      = 4'd4;
   localparam logic [3:0] EV_UNSUBACK    = 4'd5;
   localparam logic [3:0] EV_PINGRESP    = 4'd6;
   localparam logic [3:0] EV_PUBACK      = 4'd7;
   localparam logic [3:0] EV_UNHANDLED   = 4'd8;
   localparam logic [3:0] EV_BAD_LENGTH  = 4'd9;
   localparam logic [3:0] EV_BAD_CONNACK = 4'd10;
   localparam logic [3:0] EV_BAD_TOPIC   = 4'd11;
   localparam logic [3:0] EV_BAD_ID      = 4'd12;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic [3:0]       byte_kind;
      logic [3:0]       packet_type;
      logic [1:0]       qos_level;
      logic             packet_end;
      logic [3:0]       event_res;
      logic [7:0]       connack_code;
      logic [15:0]      packet_ident;
      logic             send_puback;
      logic [LEN_W-1:0] remaining_length;
   } rsp_type;

endpackage

[sv/mqttd_if.sv]
// Valid/ready channel interfaces of the MQTT receive deframer.
// Depends on mqttd_pkg for the remaining-length field width.
interface mqttd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mqttd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [7:0]                    data_byte;
   logic [3:0]                    byte_kind;
   logic [3:0]                    packet_type;
   logic [1:0]                    qos_level;
   logic                          packet_end;
   logic [3:0]                    event_res;
   logic [7:0]                    connack_code;
   logic [15:0]                   packet_ident;
   logic                          send_puback;
   logic [mqttd_pkg::LEN_W-1:0]   remaining_length;

   modport source (output valid, output data_byte, output byte_kind, output packet_type,
                   output qos_level, output packet_end, output event_res,
                   output connack_code, output packet_ident, output send_puback,
                   output remaining_length, input ready);
   modport sink   (input valid, input data_byte, input byte_kind, input packet_type,
                   input qos_level, input packet_end, input event_res,
                   input connack_code, input packet_ident, input send_puback,
                   input remaining_length, output ready);
endinterface

[sv/mqttd_parse.sv]
// Packet parser state and per-byte result logic of the MQTT receive deframer.
// Depends on mqttd_pkg.
module mqttd_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        rx_byte,
   output mqttd_pkg::rsp_type result
);

   localparam int unsigned LW = mqttd_pkg::LEN_W;

   logic [1:0]              phase_ff, phase_in;
   logic [7:0]              header_ff, header_in;
   logic [LW-1:0]           length_ff, length_in;
   logic [mqttd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [LW-1:0]           pos_ff, pos_in;
   logic [15:0]             topic_len_ff, topic_len_in;
   logic [15:0]             ident_ff, ident_in;
   logic [7:0]              connack_ff, connack_in;

   logic [LW-1:0]           len_add;
   logic [LW:0]             pos_plus1;
   logic [16:0]             tl_plus2;
   logic [16:0]             tl_plus4;
   logic [LW-1:0]           fin_tl2;
   logic [LW-1:0]           fin_tl4;
   logic                    qos_nz;
   logic                    finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mqttd_pkg::PH_HEADER;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= '0;
         length_ff    <= '0;
         pos_ff       <= '0;
         topic_len_ff <= '0;
         ident_ff     <= '0;
         connack_ff   <= '0;
      end else if (step) begin
         header_ff    <= header_in;
         length_ff    <= length_in;
         pos_ff       <= pos_in;
         topic_len_ff <= topic_len_in;
         ident_ff     <= ident_in;
         connack_ff   <= connack_in;
      end
   end

   // length byte weight: 7 bits per byte already taken
   always_comb begin
      unique case (count_ff[1:0])
         2'd0: len_add = {21'd0, rx_byte[6:0]};
         2'd1: len_add = {14'd0, rx_byte[6:0], 7'd0};
         2'd2: len_add = {7'd0, rx_byte[6:0], 14'd0};
         2'd3: len_add = {rx_byte[6:0], 21'd0};
      endcase
   end

   assign pos_plus1 = {1'b0, pos_ff} + {{LW{1'b0}}, 1'b1};
   assign tl_plus2  = {1'b0, topic_len_ff} + 17'd2;
   assign tl_plus4  = {1'b0, topic_len_ff} + 17'd4;
   assign qos_nz    = (header_ff[2:1] != 2'd0);

   // checks at packet end use the updated topic length
   assign fin_tl2 = {{(LW-16){1'b0}}, topic_len_in} + LW'(2);
   assign fin_tl4 = {{(LW-16){1'b0}}, topic_len_in} + LW'(4);

   always_comb begin
      phase_in     = phase_ff;
      header_in    = header_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      topic_len_in = topic_len_ff;
      ident_in     = ident_ff;
      connack_in   = connack_ff;
      finish       = 1'b0;
      result            = '0;
      result.data_byte  = rx_byte;
      result.packet_type = header_ff[7:4];
      result.qos_level   = header_ff[2:1];

      unique case (phase_ff)
         mqttd_pkg::PH_HALT: begin
            result.byte_kind   = mqttd_pkg::KIND_DISCARD;
            result.packet_type = 4'd0;
            result.qos_level   = 2'd0;
         end
         mqttd_pkg::PH_HEADER: begin
            header_in    = rx_byte;
            length_in    = '0;
            count_in     = '0;
            pos_in       = '0;
            topic_len_in = '0;
            ident_in     = '0;
            connack_in   = '0;
            phase_in     = mqttd_pkg::PH_LENGTH;
            result.byte_kind   = mqttd_pkg::KIND_HEADER;
            result.packet_type = rx_byte[7:4];
            result.qos_level   = rx_byte[2:1];
         end
         mqttd_pkg::PH_LENGTH: begin
            result.byte_kind = mqttd_pkg::KIND_LENGTH;
            if (count_ff >= mqttd_pkg::CNT_W'(mqttd_pkg::MAX_LENGTH_BYTES)) begin
               phase_in                = mqttd_pkg::PH_HALT;
               result.packet_end       = 1'b1;
               result.event_res        = mqttd_pkg::EV_BAD_LENGTH;
               result.remaining_length = length_ff;
            end else begin
               length_in = length_ff + len_add;
               count_in  = count_ff + mqttd_pkg::CNT_W'(1);
               result.remaining_length = length_in;
               if (!rx_byte[7]) begin
                  pos_in = '0;
                  if (length_in == '0) begin
                     phase_in = mqttd_pkg::PH_HEADER;
                     finish   = 1'b1;
                  end else begin
                     phase_in = mqttd_pkg::PH_BODY;
                  end
               end
            end
         end
         mqttd_pkg::PH_BODY: begin
            result.remaining_length = length_ff;
            if (header_ff[7:4] == mqttd_pkg::TYPE_CONNACK) begin
               result.byte_kind = mqttd_pkg::KIND_CONNACK;
               if (pos_ff == LW'(1)) connack_in = rx_byte;
            end else if (header_ff[7:4] == mqttd_pkg::TYPE_PUBLISH) begin
               priority if (pos_ff == '0) begin
                  topic_len_in     = {rx_byte, 8'd0};
                  result.byte_kind = mqttd_pkg::KIND_TOPIC_LEN;
               end else if (pos_ff == LW'(1)) begin
                  topic_len_in     = {topic_len_ff[15:8], rx_byte};
                  result.byte_kind = mqttd_pkg::KIND_TOPIC_LEN;
               end else if (pos_ff < {{(LW-17){1'b0}}, tl_plus2}) begin
                  result.byte_kind = mqttd_pkg::KIND_TOPIC;
               end else if (qos_nz && (pos_ff < {{(LW-17){1'b0}}, tl_plus4})) begin
                  if (pos_ff == {{(LW-17){1'b0}}, tl_plus2}) ident_in = {rx_byte, 8'd0};
                  else ident_in = {ident_ff[15:8], rx_byte};
                  result.byte_kind = mqttd_pkg::KIND_PKT_ID;
               end else begin
                  result.byte_kind = mqttd_pkg::KIND_PAYLOAD;
               end
            end else begin
               result.byte_kind = mqttd_pkg::KIND_OTHER;
            end
            pos_in = pos_plus1[LW-1:0];
            if (pos_plus1 >= {1'b0, length_ff}) begin
               phase_in = mqttd_pkg::PH_HEADER;
               finish   = 1'b1;
            end
         end
      endcase

      if (finish) begin
         result.packet_end = 1'b1;
         if (header_in[7:4] == mqttd_pkg::TYPE_CONNACK) begin
            if (length_in < LW'(2)) begin
               result.event_res = mqttd_pkg::EV_BAD_CONNACK;
            end else begin
               result.event_res    = (connack_in == 8'd0) ? mqttd_pkg::EV_CONNACK_OK
                                                          : mqttd_pkg::EV_CONNACK_REJ;
               result.connack_code = connack_in;
            end
         end else if (header_in[7:4] == mqttd_pkg::TYPE_PUBLISH) begin
            if (length_in < LW'(2) || fin_tl2 > length_in) begin
               result.event_res = mqttd_pkg::EV_BAD_TOPIC;
            end else if (qos_nz && fin_tl4 > length_in) begin
               result.event_res = mqttd_pkg::EV_BAD_ID;
            end else begin
               result.event_res    = mqttd_pkg::EV_PUBLISH;
               result.packet_ident = qos_nz ? ident_in : 16'd0;
               result.send_puback  = (header_in[2:1] == 2'd1);
            end
         end else if (header_in[7:4] == mqttd_pkg::TYPE_SUBACK) begin
            result.event_res = mqttd_pkg::EV_SUBACK;
         end else if (header_in[7:4] == mqttd_pkg::TYPE_UNSUBACK) begin
            result.event_res = mqttd_pkg::EV_UNSUBACK;
         end else if (header_in[7:4] == mqttd_pkg::TYPE_PINGRESP) begin
            result.event_res = mqttd_pkg::EV_PINGRESP;
         end else if (header_in[7:4] == mqttd_pkg::TYPE_PUBACK) begin
            result.event_res = mqttd_pkg::EV_PUBACK;
         end else begin
            result.event_res = mqttd_pkg::EV_UNHANDLED;
         end
      end
   end

   // halt only leaves through reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == mqttd_pkg::PH_HALT |=> phase_ff == mqttd_pkg::PH_HALT)
      else $error("parser left halt without reset");

   // every event closes a packet and every packet close carries an event
   a_end_event: assert property (@(posedge clock) disable iff (reset)
      step |-> (result.packet_end == (result.event_res != mqttd_pkg::EV_NONE)))
      else $error("packet end and event disagree");

   a_puback_qos1: assert property (@(posedge clock) disable iff (reset)
      (step && result.send_puback) |->
         (result.event_res == mqttd_pkg::EV_PUBLISH && result.qos_level == 2'd1))
      else $error("puback request outside a QoS 1 publish");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mqttd_pkg::CNT_W'(mqttd_pkg::MAX_LENGTH_BYTES))
      else $error("length byte count past its limit");

   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == mqttd_pkg::PH_BODY |-> length_ff != '0)
      else $error("body phase with zero remaining length");

endmodule

[sv/mqtt_receive_deframer_top.sv]
// Top level of the MQTT receive deframer: input register, parser, result register.
// Depends on mqttd_pkg, mqttd_if (channel interfaces) and mqttd_parse.
//
// Usage:
//   req_if carries one received byte (rx_byte) per transfer. rsp_if returns
//   exactly one tagged result per byte, in order: the byte itself, its class,
//   the packet type and QoS, the decoded remaining length and, on the last
//   byte of a packet, packet_end with an event (CONNACK, PUBLISH with packet
//   identifier and PUBACK request, acknowledgements, or an error code).
//   Pipeline: two register stages, input register and result register; a byte
//   in the input register passes through the parser into the result register.
//   Throughput: one byte per cycle, sustained while rsp_if.ready stays high; the
//   parser updates all of its counters in a single pass per byte.
//   Stalls: while rsp_if.ready is low the result holds; the input register
//   still takes one more byte, then req_if.ready drops until the result
//   drains. No byte is lost or repeated.
//   Reset (synchronous, active high): both stages empty, parser waits for a
//   fixed header byte. An over-long remaining length halts the parser;
//   every later byte comes back marked discarded until the next reset.
module mqtt_receive_deframer_top (
   input logic          clock,
   input logic          reset,
   mqttd_req_if.sink    req_if,
   mqttd_rsp_if.source  rsp_if
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                out_valid_ff, out_valid_in;
   mqttd_pkg::rsp_type  out_ff, out_in;
   logic                advance;
   logic                req_take;

   // parser fires when the input register holds a byte and the result slot is free
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign in_byte_in   = req_take ? req_if.rx_byte : in_byte_ff;
   assign out_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   mqttd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (advance) out_ff <= out_in;
   end

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.data_byte        = out_ff.data_byte;
   assign rsp_if.byte_kind        = out_ff.byte_kind;
   assign rsp_if.packet_type      = out_ff.packet_type;
   assign rsp_if.qos_level        = out_ff.qos_level;
   assign rsp_if.packet_end       = out_ff.packet_end;
   assign rsp_if.event_res        = out_ff.event_res;
   assign rsp_if.connack_code     = out_ff.connack_code;
   assign rsp_if.packet_ident     = out_ff.packet_ident;
   assign rsp_if.send_puback      = out_ff.send_puback;
   assign rsp_if.remaining_length = out_ff.remaining_length;

endmodule

[tb/sv/mqtt_receive_deframer_top_test.sv]
// Self-checking testbench for the MQTT receive deframer top level.
// Needs mqttd_pkg, mqttd_if and mqtt_receive_deframer_top; fully self-contained.
// Drives byte streams of MQTT packets and checks every tagged result per byte.
`timescale 1ns / 1ps

module mqtt_receive_deframer_top_test;

   localparam int unsigned CYCLE_LIMIT  = 100000;  // far above a slow correct run
   localparam int unsigned RANDOM_BYTES = 1320;
   localparam int unsigned IDLE_PCT     = 17;

   // One row of the hand-written stimulus: the byte and, where obvious,
   // the result it must produce.
   typedef struct {
      logic [7:0]         rx;
      bit                 typed;
      mqttd_pkg::rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   mqttd_req_if req_if ();
   mqttd_rsp_if rsp_if ();

   mqtt_receive_deframer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Parser mirror: state of the packet currently being walked
   // ---------------------------------------------------------------------
   logic [1:0]  parse_phase = mqttd_pkg::PH_HEADER;
   logic [7:0]  head_byte   = '0;
   logic [27:0] body_len    = '0;
   int unsigned len_bytes   = 0;
   int unsigned body_at     = 0;
   logic [15:0] topic_len   = '0;
   logic [15:0] pkt_ident   = '0;
   logic [7:0]  ack_code    = '0;

   mqttd_pkg::rsp_type tagged_due[$];    // results still owed by the block, oldest first
   int unsigned mismatches  = 0;
   int unsigned bytes_sent  = 0;
   int unsigned cycle_count = 0;
   logic        steady;           // window where neither side idles

   assign steady = (cycle_count >= 1200) && (cycle_count < 1700);

   function automatic mqttd_pkg::rsp_type literal_rsp(logic [7:0] b, logic [3:0] kind,
                                                      logic [3:0] ptype, logic [1:0] qos,
                                                      logic last, logic [3:0] ev,
                                                      logic [7:0] code, logic [27:0] rlen);
      mqttd_pkg::rsp_type r;
      r = '0;
      r.data_byte        = b;
      r.byte_kind        = kind;
      r.packet_type      = ptype;
      r.qos_level        = qos;
      r.packet_end       = last;
      r.event_res        = ev;
      r.connack_code     = code;
      r.remaining_length = rlen;
      return r;
   endfunction

   // Event of a packet whose last byte has just come in
   function automatic mqttd_pkg::rsp_type close_packet(mqttd_pkg::rsp_type r);
      int unsigned tl;
      tl = 32'(topic_len);
      r.packet_end = 1'b1;
      unique case (head_byte[7:4])
         mqttd_pkg::TYPE_CONNACK: begin
            if (body_len < 2) begin
               r.event_res = mqttd_pkg::EV_BAD_CONNACK;
            end else begin
               r.event_res    = (ack_code == 0) ? mqttd_pkg::EV_CONNACK_OK
                                                : mqttd_pkg::EV_CONNACK_REJ;
               r.connack_code = ack_code;
            end
         end
         mqttd_pkg::TYPE_PUBLISH: begin
            if (body_len < 2 || 2 + tl > body_len) begin
               r.event_res = mqttd_pkg::EV_BAD_TOPIC;
            end else if (head_byte[2:1] != 0 && 4 + tl > body_len) begin
               r.event_res = mqttd_pkg::EV_BAD_ID;
            end else begin
               r.event_res    = mqttd_pkg::EV_PUBLISH;
               r.packet_ident = (head_byte[2:1] != 0) ? pkt_ident : 16'h0000;
               r.send_puback  = (head_byte[2:1] == 2'd1);
            end
         end
         mqttd_pkg::TYPE_SUBACK:   r.event_res = mqttd_pkg::EV_SUBACK;
         mqttd_pkg::TYPE_UNSUBACK: r.event_res = mqttd_pkg::EV_UNSUBACK;
         mqttd_pkg::TYPE_PINGRESP: r.event_res = mqttd_pkg::EV_PINGRESP;
         mqttd_pkg::TYPE_PUBACK:   r.event_res = mqttd_pkg::EV_PUBACK;
         default:                  r.event_res = mqttd_pkg::EV_UNHANDLED;
      endcase
      return r;
   endfunction

   // Advances the mirror by one byte and returns the tagged result
   function automatic mqttd_pkg::rsp_type parse_byte(logic [7:0] b);
      mqttd_pkg::rsp_type r;
      int unsigned        at;
      int unsigned        tl;
      r = '0;
      r.data_byte = b;
      if (parse_phase == mqttd_pkg::PH_HALT) begin
         r.byte_kind = mqttd_pkg::KIND_DISCARD;
         return r;
      end
      if (parse_phase == mqttd_pkg::PH_HEADER) begin
         head_byte   = b;
         body_len    = '0;
         len_bytes   = 0;
         body_at     = 0;
         topic_len   = '0;
         pkt_ident   = '0;
         ack_code    = '0;
         parse_phase = mqttd_pkg::PH_LENGTH;
         r.byte_kind   = mqttd_pkg::KIND_HEADER;
         r.packet_type = b[7:4];
         r.qos_level   = b[2:1];
         return r;
      end
      r.packet_type = head_byte[7:4];
      r.qos_level   = head_byte[2:1];
      if (parse_phase == mqttd_pkg::PH_LENGTH) begin
         r.byte_kind = mqttd_pkg::KIND_LENGTH;
         // one length byte too many: flag it and stop for good
         if (len_bytes >= mqttd_pkg::MAX_LENGTH_BYTES || len_bytes >= 4) begin
            parse_phase        = mqttd_pkg::PH_HALT;
            r.packet_end       = 1'b1;
            r.event_res        = mqttd_pkg::EV_BAD_LENGTH;
            r.remaining_length = body_len;
            return r;
         end
         body_len = body_len + (28'(b[6:0]) << (7 * len_bytes));
         len_bytes++;
         r.remaining_length = body_len;
         if (!b[7]) begin
            body_at = 0;
            if (body_len == 0) begin
               parse_phase = mqttd_pkg::PH_HEADER;
               r = close_packet(r);
            end else begin
               parse_phase = mqttd_pkg::PH_BODY;
            end
         end
         return r;
      end
      // body byte: PUBLISH bytes are classed by position only
      at = body_at;
      tl = 32'(topic_len);
      r.remaining_length = body_len;
      if (head_byte[7:4] == mqttd_pkg::TYPE_CONNACK) begin
         r.byte_kind = mqttd_pkg::KIND_CONNACK;
         if (at == 1) ack_code = b;
      end else if (head_byte[7:4] == mqttd_pkg::TYPE_PUBLISH) begin
         if (at == 0) begin
            topic_len   = {b, 8'h00};
            r.byte_kind = mqttd_pkg::KIND_TOPIC_LEN;
         end else if (at == 1) begin
            topic_len[7:0] = b;
            r.byte_kind    = mqttd_pkg::KIND_TOPIC_LEN;
         end else if (at < 2 + tl) begin
            r.byte_kind = mqttd_pkg::KIND_TOPIC;
         end else if (head_byte[2:1] != 0 && at < 4 + tl) begin
            if (at == 2 + tl) pkt_ident = {b, 8'h00};
            else pkt_ident[7:0] = b;
            r.byte_kind = mqttd_pkg::KIND_PKT_ID;
         end else begin
            r.byte_kind = mqttd_pkg::KIND_PAYLOAD;
         end
      end else begin
         r.byte_kind = mqttd_pkg::KIND_OTHER;
      end
      body_at = at + 1;
      if (at + 1 >= body_len) begin
         parse_phase = mqttd_pkg::PH_HEADER;
         r = close_packet(r);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // One transfer on the request channel; the expectation is queued at the
   // accepting edge. Random idle cycles go in front, except in the steady window.
   task automatic send_byte(logic [7:0] b, bit typed, mqttd_pkg::rsp_type want);
      mqttd_pkg::rsp_type guess;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      guess = parse_byte(b);
      tagged_due.push_back(typed ? want : guess);
      bytes_sent++;
   endtask

   // Stop sending until every owed result has come back
   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tagged_due.size() != 0) @(posedge clock);
   endtask

   // One random packet: mostly well formed with random content, some cut
   // short, some with padded length fields, some pure noise.
   task automatic send_packet();
      logic [7:0]         head;
      logic [7:0]         frame[$];
      logic [7:0]         len_field[$];
      int unsigned        pick;
      int unsigned        tl;
      int unsigned        plen;
      int unsigned        blen;
      int unsigned        lenv;
      int unsigned        pad;
      mqttd_pkg::rsp_type none;
      none = '0;
      pick = $urandom_range(99);
      head = 8'($urandom);
      frame = {};
      if (pick < 40) begin
         head[7:4] = mqttd_pkg::TYPE_PUBLISH;
         tl   = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
         plen = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(10);
         frame.push_back(8'(tl >> 8));
         frame.push_back(8'(tl));
         repeat (tl) frame.push_back(8'($urandom));
         if (head[2:1] != 0) begin
            frame.push_back(8'($urandom));
            frame.push_back(8'($urandom));
         end
         repeat (plen) frame.push_back(8'($urandom));
         // garbage topic length now and then
         if ($urandom_range(9) == 0) frame[0] = 8'($urandom);
      end else if (pick < 55) begin
         head[7:4] = mqttd_pkg::TYPE_CONNACK;
         frame.push_back({7'b0, 1'($urandom)});
         frame.push_back($urandom_range(1) ? 8'h00 : 8'($urandom));
         repeat ($urandom_range(3) == 0) frame.push_back(8'($urandom));
      end else if (pick < 85) begin
         case ($urandom_range(3))
            0: head[7:4] = mqttd_pkg::TYPE_PUBACK;
            1: head[7:4] = mqttd_pkg::TYPE_SUBACK;
            2: head[7:4] = mqttd_pkg::TYPE_UNSUBACK;
            default: head[7:4] = mqttd_pkg::TYPE_PINGRESP;
         endcase
         repeat ($urandom_range(4)) frame.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(6)) frame.push_back(8'($urandom));
      end

      blen = frame.size();
      if ($urandom_range(7) == 0) blen = $urandom_range(blen);

      // remaining length, low group first, sometimes padded with empty groups
      lenv = blen;
      len_field = {};
      do begin
         len_field.push_back({lenv > 127, 7'(lenv)});
         lenv = lenv >> 7;
      end while (lenv != 0);
      pad = ($urandom_range(5) == 0) ? $urandom_range(4 - len_field.size()) : 0;
      if (pad > 0) begin
         len_field[len_field.size() - 1] |= 8'h80;
         repeat (pad - 1) len_field.push_back(8'h80);
         len_field.push_back(8'h00);
      end

      send_byte(head, 1'b0, none);
      foreach (len_field[i]) send_byte(len_field[i], 1'b0, none);
      for (int unsigned i = 0; i < blen; i++) send_byte(frame[i], 1'b0, none);
   endtask

   // ---------------------------------------------------------------------
   // Receiver side: random back-pressure and in-order checking
   // ---------------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_check
      mqttd_pkg::rsp_type got;
      mqttd_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.data_byte        = rsp_if.data_byte;
         got.byte_kind        = rsp_if.byte_kind;
         got.packet_type      = rsp_if.packet_type;
         got.qos_level        = rsp_if.qos_level;
         got.packet_end       = rsp_if.packet_end;
         got.event_res        = rsp_if.event_res;
         got.connack_code     = rsp_if.connack_code;
         got.packet_ident     = rsp_if.packet_ident;
         got.send_puback      = rsp_if.send_puback;
         got.remaining_length = rsp_if.remaining_length;
         if (tagged_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual byte %0h",
                     $time, got.data_byte);
            mismatches++;
         end else begin
            want = tagged_due.pop_front();
            check_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
            check_field("byte_kind", 32'(got.byte_kind), 32'(want.byte_kind));
            check_field("packet_type", 32'(got.packet_type), 32'(want.packet_type));
            check_field("qos_level", 32'(got.qos_level), 32'(want.qos_level));
            check_field("packet_end", 32'(got.packet_end), 32'(want.packet_end));
            check_field("event_res", 32'(got.event_res), 32'(want.event_res));
            check_field("connack_code", 32'(got.connack_code), 32'(want.connack_code));
            check_field("packet_ident", 32'(got.packet_ident), 32'(want.packet_ident));
            check_field("send_puback", 32'(got.send_puback), 32'(want.send_puback));
            check_field("remaining_length", 32'(got.remaining_length),
                        32'(want.remaining_length));
         end
      end
      rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type       opening[$];
      stim_row_type       closing[$];
      bit                 drained_once;
      mqttd_pkg::rsp_type none;
      none = '0;
      drained_once = 1'b0;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = 8'h00;

      opening = '{
         // PINGRESP with empty body: event on the length byte
         '{8'hD0, 1'b1, literal_rsp(8'hD0, mqttd_pkg::KIND_HEADER,
                                    mqttd_pkg::TYPE_PINGRESP, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'd0)},
         '{8'h00, 1'b1, literal_rsp(8'h00, mqttd_pkg::KIND_LENGTH,
                                    mqttd_pkg::TYPE_PINGRESP, 2'd0, 1'b1,
                                    mqttd_pkg::EV_PINGRESP, 8'h00, 28'd0)},
         // CONNACK with zero length is malformed
         '{8'h20, 1'b1, literal_rsp(8'h20, mqttd_pkg::KIND_HEADER,
                                    mqttd_pkg::TYPE_CONNACK, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'd0)},
         '{8'h00, 1'b1, literal_rsp(8'h00, mqttd_pkg::KIND_LENGTH,
                                    mqttd_pkg::TYPE_CONNACK, 2'd0, 1'b1,
                                    mqttd_pkg::EV_BAD_CONNACK, 8'h00, 28'd0)},
         // CONNACK refused with return code 5
         '{8'h20, 1'b1, literal_rsp(8'h20, mqttd_pkg::KIND_HEADER,
                                    mqttd_pkg::TYPE_CONNACK, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'd0)},
         '{8'h02, 1'b1, literal_rsp(8'h02, mqttd_pkg::KIND_LENGTH,
                                    mqttd_pkg::TYPE_CONNACK, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'd2)},
         '{8'h00, 1'b1, literal_rsp(8'h00, mqttd_pkg::KIND_CONNACK,
                                    mqttd_pkg::TYPE_CONNACK, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'd2)},
         '{8'h05, 1'b1, literal_rsp(8'h05, mqttd_pkg::KIND_CONNACK,
                                    mqttd_pkg::TYPE_CONNACK, 2'd0, 1'b1,
                                    mqttd_pkg::EV_CONNACK_REJ, 8'h05, 28'd2)},
         // QoS 1 PUBLISH with a one-byte body: topic length cut short
         '{8'h32, 1'b1, literal_rsp(8'h32, mqttd_pkg::KIND_HEADER,
                                    mqttd_pkg::TYPE_PUBLISH, 2'd1, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'd0)},
         '{8'h01, 1'b1, literal_rsp(8'h01, mqttd_pkg::KIND_LENGTH,
                                    mqttd_pkg::TYPE_PUBLISH, 2'd1, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'd1)},
         '{8'h00, 1'b1, literal_rsp(8'h00, mqttd_pkg::KIND_TOPIC_LEN,
                                    mqttd_pkg::TYPE_PUBLISH, 2'd1, 1'b1,
                                    mqttd_pkg::EV_BAD_TOPIC, 8'h00, 28'd1)},
         // QoS 3 PUBLISH, identifier cut short
         '{8'h36, 1'b0, none}, '{8'h03, 1'b0, none}, '{8'h00, 1'b0, none},
         '{8'h00, 1'b0, none}, '{8'h12, 1'b0, none},
         // reserved type, four length bytes adding up to zero
         '{8'hF1, 1'b0, none}, '{8'h80, 1'b0, none}, '{8'h80, 1'b0, none},
         '{8'h80, 1'b0, none}, '{8'h00, 1'b0, none}
      };

      // fifth length byte halts the parser; later bytes come back discarded
      closing = '{
         '{8'h40, 1'b1, literal_rsp(8'h40, mqttd_pkg::KIND_HEADER,
                                    mqttd_pkg::TYPE_PUBACK, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'd0)},
         '{8'hFF, 1'b1, literal_rsp(8'hFF, mqttd_pkg::KIND_LENGTH,
                                    mqttd_pkg::TYPE_PUBACK, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'h000007F)},
         '{8'hFF, 1'b1, literal_rsp(8'hFF, mqttd_pkg::KIND_LENGTH,
                                    mqttd_pkg::TYPE_PUBACK, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'h0003FFF)},
         '{8'hFF, 1'b1, literal_rsp(8'hFF, mqttd_pkg::KIND_LENGTH,
                                    mqttd_pkg::TYPE_PUBACK, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'h01FFFFF)},
         '{8'hFF, 1'b1, literal_rsp(8'hFF, mqttd_pkg::KIND_LENGTH,
                                    mqttd_pkg::TYPE_PUBACK, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'hFFFFFFF)},
         '{8'h55, 1'b1, literal_rsp(8'h55, mqttd_pkg::KIND_LENGTH,
                                    mqttd_pkg::TYPE_PUBACK, 2'd0, 1'b1,
                                    mqttd_pkg::EV_BAD_LENGTH, 8'h00, 28'hFFFFFFF)},
         '{8'h00, 1'b1, literal_rsp(8'h00, mqttd_pkg::KIND_DISCARD, 4'h0, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'd0)},
         '{8'hFF, 1'b1, literal_rsp(8'hFF, mqttd_pkg::KIND_DISCARD, 4'h0, 2'd0, 1'b0,
                                    mqttd_pkg::EV_NONE, 8'h00, 28'd0)}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) send_byte(opening[i].rx, opening[i].typed, opening[i].want);

      // random packets; one full drain in the middle
      while (bytes_sent < RANDOM_BYTES) begin
         if (!drained_once && bytes_sent > 700) begin
            hold_until_drained();
            drained_once = 1'b1;
         end
         send_packet();
      end

      // the halt is sticky, so it goes last; start it on a packet boundary
      while (parse_phase != mqttd_pkg::PH_HEADER) send_byte(8'($urandom), 1'b0, none);
      foreach (closing[i]) send_byte(closing[i].rx, closing[i].typed, closing[i].want);

      hold_until_drained();
      repeat (6) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
